[src/sdo_pkg.sv]
`timescale 1ns / 1ps

package sdo_pkg;

   localparam int BUFFER_BYTES_DEFAULT = 1024;

   // Request types carried in req_type.
   localparam logic [2:0] REQ_LOAD     = 3'd0;
   localparam logic [2:0] REQ_START_DL = 3'd1;
   localparam logic [2:0] REQ_START_UL = 3'd2;
   localparam logic [2:0] REQ_FRAME    = 3'd3;
   localparam logic [2:0] REQ_TIMEOUT  = 3'd4;
   localparam logic [2:0] REQ_READ     = 3'd5;

   // Command specifiers in bits 7..5 of frame byte 0.
   localparam logic [2:0] CMD_DL_SEG  = 3'd0;
   localparam logic [2:0] CMD_INIT_DL = 3'd1;
   localparam logic [2:0] CMD_INIT_UL = 3'd2;
   localparam logic [2:0] CMD_UL_SEG  = 3'd3;
   localparam logic [2:0] CMD_ABORT   = 3'd4;

   localparam logic [31:0] CODE_GENERAL = 32'h0800_0000;
   localparam logic [31:0] CODE_TOGGLE  = 32'h0503_0000;
   localparam logic [31:0] CODE_LENGTH  = 32'h0607_0010;
   localparam logic [31:0] CODE_TIMEOUT = 32'h0504_0000;

   typedef enum logic [1:0] {MEM_NONE, MEM_READ, MEM_WRITE} mem_op_type;

   typedef enum logic [1:0] {SEQ_IDLE, SEQ_DECIDE, SEQ_MEM, SEQ_RESP} seq_state_type;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [15:0] object_index;
      logic [7:0]  object_subindex;
      logic [10:0] transfer_len;
      logic [9:0]  byte_addr;
      logic [7:0]  byte_value;
      logic [63:0] frame_bytes;
   } req_word_type;

   typedef struct packed {
      logic        tx_valid;
      logic [63:0] tx_bytes;
      logic        finished;
      logic        succeeded;
      logic [31:0] abort_reason;
      logic [7:0]  read_value;
      logic [10:0] final_length;
   } rsp_word_type;

   typedef struct packed {
      logic [10:0] offset;
      logic [10:0] total;
      logic [2:0]  last_cmd;
      logic        toggle;
      logic [15:0] index;
      logic [7:0]  subindex;
      logic        active;
   } engine_state_type;

   // Outcome of one word: next engine state, frame header and the buffer job.
   typedef struct packed {
      engine_state_type nxt;
      logic             tx_valid;
      logic [63:0]      tx_head;
      logic             finished;
      logic [31:0]      abort_reason;
      mem_op_type       mem_op;
      logic [10:0]      mem_base;
      logic [2:0]       mem_count;
      logic [2:0]       mem_lane;
      logic             mem_to_read;
      logic             mem_from_value;
   } decision_type;

   function automatic logic [63:0] head_frame(input logic [7:0] byte0,
                                              input logic [15:0] idx,
                                              input logic [7:0] sub);
      return {32'b0, sub, idx, byte0};
   endfunction

endpackage

[src/sdo_if.sv]
`timescale 1ns / 1ps

interface sdo_req_if import sdo_pkg::*; ();
   logic         valid;
   logic         ready;
   req_word_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface sdo_rsp_if import sdo_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_word_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[src/sdo_mem.sv]
`timescale 1ns / 1ps

module sdo_mem #(
   parameter int Depth = 1024,
   parameter int AddrBits = 10
) (
   input  logic                clock,
   input  logic                we,
   input  logic [AddrBits-1:0] addr,
   input  logic [7:0]          wdata,
   output logic [7:0]          rdata
);

   logic [7:0] store [Depth];

   always_ff @(posedge clock) begin
      if (we) begin
         store[addr] <= wdata;
      end
      rdata <= store[addr];
   end

endmodule

[src/sdo_decode.sv]
`timescale 1ns / 1ps

module sdo_decode import sdo_pkg::*; #(
   parameter int BufferBytes = BUFFER_BYTES_DEFAULT
) (
   input  req_word_type     req,
   input  engine_state_type st,
   output decision_type     dec
);

   logic [7:0]  b0;
   logic [2:0]  fcmd;
   logic        tog;
   logic        same;
   logic [31:0] hi32;
   logic [31:0] ds;
   logic [10:0] rem;
   logic [2:0]  seg_size;
   logic        seg_done;
   logic [2:0]  un;
   logic [31:0] lim;
   logic [10:0] len_clamp;
   logic [10:0] ds_clamp;
   logic [10:0] up_total;
   logic [10:0] up_off;
   logic [31:0] rsn;
   logic        fin;
   logic        do_seg;
   logic        seg_tog;
   logic        do_ulseg;
   logic        ul_tog;
   logic        addr_ok;

   always_comb begin
      b0        = req.frame_bytes[7:0];
      fcmd      = b0[7:5];
      tog       = b0[4];
      same      = (req.frame_bytes[23:8] == st.index) && (req.frame_bytes[31:24] == st.subindex);
      hi32      = req.frame_bytes[63:32];
      rem       = st.total - st.offset;
      seg_size  = (rem > 11'd7) ? 3'd7 : rem[2:0];
      seg_done  = (11'(seg_size) == rem);
      un        = 3'd7 - b0[3:1];
      lim       = (st.total != 11'd0) ? 32'(st.total) : 32'(BufferBytes);
      len_clamp = (32'(req.transfer_len) > 32'(BufferBytes)) ?
                  11'(BufferBytes) : req.transfer_len;
      addr_ok   = 32'(req.byte_addr) < 32'(BufferBytes);
      if (b0[1] && b0[0]) begin
         ds = 32'(3'd4 - {1'b0, b0[3:2]});
      end else if (b0[0]) begin
         ds = hi32;
      end else begin
         ds = '0;
      end
      ds_clamp = (ds > 32'(BufferBytes)) ? 11'(BufferBytes) : ds[10:0];
      up_total = '0;
      up_off   = '0;
      rsn      = '0;
      fin      = 1'b0;
      do_seg   = 1'b0;
      seg_tog  = 1'b0;
      do_ulseg = 1'b0;
      ul_tog   = 1'b0;
      dec      = '0;
      dec.nxt  = st;
      dec.mem_op = MEM_NONE;

      case (req.req_type)
         REQ_LOAD: begin
            if (addr_ok) begin
               dec.mem_op         = MEM_WRITE;
               dec.mem_base       = 11'(req.byte_addr);
               dec.mem_count      = 3'd1;
               dec.mem_from_value = 1'b1;
            end
         end
         REQ_READ: begin
            if (addr_ok) begin
               dec.mem_op      = MEM_READ;
               dec.mem_base    = 11'(req.byte_addr);
               dec.mem_count   = 3'd1;
               dec.mem_to_read = 1'b1;
            end
         end
         REQ_START_DL, REQ_START_UL: begin
            dec.nxt.index    = req.object_index;
            dec.nxt.subindex = req.object_subindex;
            dec.nxt.total    = len_clamp;
            dec.nxt.offset   = '0;
            dec.nxt.active   = 1'b1;
            dec.nxt.toggle   = 1'b0;
            dec.tx_valid     = 1'b1;
            if (req.req_type == REQ_START_UL) begin
               dec.tx_head      = head_frame(8'h40, req.object_index, req.object_subindex);
               dec.nxt.last_cmd = CMD_INIT_UL;
            end else if (len_clamp > 11'd4) begin
               dec.tx_head = head_frame(8'h21, req.object_index, req.object_subindex)
                             | {21'b0, len_clamp, 32'b0};
               dec.nxt.last_cmd = CMD_INIT_DL;
            end else begin
               // Expedited download: up to four buffer bytes ride in bytes 4..7.
               dec.tx_head = head_frame({4'h2, 2'(3'd4 - len_clamp[2:0]), 2'b11},
                                        req.object_index, req.object_subindex);
               dec.nxt.last_cmd = CMD_INIT_DL;
               dec.nxt.offset   = len_clamp;
               dec.mem_op       = MEM_READ;
               dec.mem_base     = '0;
               dec.mem_count    = len_clamp[2:0];
               dec.mem_lane     = 3'd4;
            end
         end
         REQ_TIMEOUT: begin
            if (st.active) begin
               rsn = CODE_TIMEOUT;
            end
         end
         REQ_FRAME: begin
            if (st.active) begin
               case (fcmd)
                  CMD_UL_SEG: begin
                     // Initiate download response.
                     if (st.last_cmd != CMD_INIT_DL || !same) begin
                        rsn = CODE_GENERAL;
                     end else if (st.offset < st.total) begin
                        do_seg  = 1'b1;
                        seg_tog = 1'b0;
                     end else begin
                        fin = 1'b1;
                     end
                  end
                  CMD_INIT_DL: begin
                     // Download segment response.
                     if (st.last_cmd != CMD_DL_SEG) begin
                        rsn = CODE_GENERAL;
                     end else if (tog != st.toggle) begin
                        rsn = CODE_TOGGLE;
                     end else if (st.offset < st.total) begin
                        do_seg  = 1'b1;
                        seg_tog = ~tog;
                     end else begin
                        fin = 1'b1;
                     end
                  end
                  CMD_INIT_UL: begin
                     if (st.last_cmd != CMD_INIT_UL || !same) begin
                        rsn = CODE_GENERAL;
                     end else if (!(ds == 32'd0 || st.total == 11'd0 ||
                                    ds == 32'(st.total))) begin
                        rsn = CODE_LENGTH;
                     end else if (b0[1] && !(ds <= 32'd4 && st.total <= 11'd4)) begin
                        rsn = CODE_GENERAL;
                     end else if (b0[1]) begin
                        if (st.total == 11'd0) begin
                           up_total = b0[0] ? ds[10:0] : 11'd4;
                        end else begin
                           up_total = st.total;
                        end
                        dec.nxt.total  = up_total;
                        dec.nxt.offset = up_total;
                        dec.mem_op     = MEM_WRITE;
                        dec.mem_base   = '0;
                        dec.mem_count  = (up_total > 11'd4) ? 3'd4 : up_total[2:0];
                        dec.mem_lane   = 3'd4;
                        fin            = 1'b1;
                     end else begin
                        if (b0[0] && st.total == 11'd0) begin
                           dec.nxt.total = ds_clamp;
                        end
                        do_ulseg = 1'b1;
                        ul_tog   = 1'b0;
                     end
                  end
                  CMD_DL_SEG: begin
                     // Upload segment from the server.
                     up_off = st.offset + 11'(un);
                     if (st.last_cmd != CMD_UL_SEG) begin
                        rsn = CODE_GENERAL;
                     end else if (tog != st.toggle) begin
                        rsn = CODE_TOGGLE;
                     end else if (32'(st.offset) + 32'(un) > lim) begin
                        rsn = CODE_LENGTH;
                     end else begin
                        dec.mem_op     = MEM_WRITE;
                        dec.mem_base   = st.offset;
                        dec.mem_count  = un;
                        dec.mem_lane   = 3'd1;
                        dec.nxt.offset = up_off;
                        if (b0[0] || up_off == st.total) begin
                           if (st.total == 11'd0) begin
                              dec.nxt.total = up_off;
                           end
                           fin = 1'b1;
                        end else begin
                           do_ulseg = 1'b1;
                           ul_tog   = ~tog;
                        end
                     end
                  end
                  CMD_ABORT: begin
                     dec.abort_reason = hi32;
                     dec.nxt.offset   = '0;
                     fin              = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
         end
      endcase

      if (do_seg) begin
         dec.tx_valid     = 1'b1;
         dec.tx_head      = {56'b0, 3'b000, seg_tog, 3'd7 - seg_size, seg_done};
         dec.mem_op       = MEM_READ;
         dec.mem_base     = st.offset;
         dec.mem_count    = seg_size;
         dec.mem_lane     = 3'd1;
         dec.nxt.offset   = st.offset + 11'(seg_size);
         dec.nxt.last_cmd = CMD_DL_SEG;
         dec.nxt.toggle   = seg_tog;
      end
      if (do_ulseg) begin
         dec.tx_valid     = 1'b1;
         dec.tx_head      = {56'b0, 3'b011, ul_tog, 4'b0000};
         dec.nxt.last_cmd = CMD_UL_SEG;
         dec.nxt.toggle   = ul_tog;
      end
      if (rsn != 32'd0) begin
         dec.tx_valid     = 1'b1;
         dec.tx_head      = head_frame(8'h80, st.index, st.subindex) | {rsn, 32'b0};
         dec.nxt.last_cmd = CMD_ABORT;
         dec.nxt.toggle   = 1'b0;
         dec.abort_reason = rsn;
         dec.nxt.offset   = '0;
         fin              = 1'b1;
      end
      if (fin) begin
         dec.nxt.active = 1'b0;
      end
      dec.finished = fin;
   end

endmodule

[src/sdo_client_transfer_engine_core.sv]
`timescale 1ns / 1ps
// An accepted word passes through the decode state, the byte loop (one buffer access
// per byte moved, 0 to 7 bytes, then the read latency when bytes are read) and the
// result state. The result waits in the output registers until taken, and the next
// word is taken in the cycle after that.
// Reset (synchronous, active high) clears the sequencer and the engine state; the
// byte buffer is not cleared and holds unknown data until written.

module sdo_client_transfer_engine_core import sdo_pkg::*; #(
   parameter int BufferBytes = BUFFER_BYTES_DEFAULT
) (
   input logic     clock,
   input logic     reset,
   sdo_req_if.sink   req_ch,
   sdo_rsp_if.source rsp_ch
);

   localparam int AddrBits = (BufferBytes > 1) ? $clog2(BufferBytes) : 1;

   seq_state_type    seq_ff, seq_in;
   engine_state_type st_ff, st_in;
   req_word_type     req_ff, req_in;
   decision_type     dec_ff, dec_in, dec;
   logic [2:0]       issue_ff, issue_in;
   logic             rd_pend_ff, rd_pend_in;
   logic [2:0]       rd_lane_ff, rd_lane_in;
   logic [63:0]      tx_ff, tx_in;
   logic [7:0]       rdval_ff, rdval_in;

   logic                issuing;
   logic [2:0]          lane;
   logic                mem_we;
   logic [AddrBits-1:0] mem_addr;
   logic [7:0]          mem_wdata;
   logic [7:0]          mem_rdata;
   logic                accept;

   // Protocol decisions for the held word are made in the decode state.
   sdo_decode #(.BufferBytes(BufferBytes)) u_decode (
      .req (req_ff),
      .st  (st_ff),
      .dec (dec)
   );

   sdo_mem #(.Depth(BufferBytes), .AddrBits(AddrBits)) u_mem (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   assign accept = req_ch.valid && req_ch.ready;

   // The byte loop issues one buffer access per cycle; read data lands in the following cycle.
   always_comb begin
      issuing   = (seq_ff == SEQ_MEM) && (issue_ff < dec_ff.mem_count) &&
                  (dec_ff.mem_op != MEM_NONE);
      lane      = dec_ff.mem_lane + issue_ff;
      mem_we    = issuing && (dec_ff.mem_op == MEM_WRITE);
      mem_addr  = AddrBits'(dec_ff.mem_base + 11'(issue_ff));
      mem_wdata = dec_ff.mem_from_value ? req_ff.byte_value :
                  8'(req_ff.frame_bytes >> {lane, 3'b000});
   end

   // Next state of the sequencer.
   always_comb begin
      seq_in = seq_ff;
      case (seq_ff)
         SEQ_IDLE: begin
            if (req_ch.valid) begin
               seq_in = SEQ_DECIDE;
            end
         end
         SEQ_DECIDE: begin
            seq_in = SEQ_MEM;
         end
         SEQ_MEM: begin
            if (!issuing && !rd_pend_ff) begin
               seq_in = SEQ_RESP;
            end
         end
         SEQ_RESP: begin
            if (rsp_ch.ready) begin
               seq_in = SEQ_IDLE;
            end
         end
         default: begin
            seq_in = SEQ_IDLE;
         end
      endcase
   end

   // Datapath and handshake outputs.
   always_comb begin
      req_in     = req_ff;
      dec_in     = dec_ff;
      st_in      = st_ff;
      issue_in   = issue_ff;
      tx_in      = tx_ff;
      rdval_in   = rdval_ff;
      rd_pend_in = issuing && (dec_ff.mem_op == MEM_READ);
      rd_lane_in = lane;
      req_ch.ready = (seq_ff == SEQ_IDLE);
      rsp_ch.valid = (seq_ff == SEQ_RESP);
      case (seq_ff)
         SEQ_IDLE: begin
            if (accept) begin
               req_in = req_ch.payload;
            end
         end
         SEQ_DECIDE: begin
            dec_in   = dec;
            st_in    = dec.nxt;
            tx_in    = dec.tx_head;
            rdval_in = '0;
            issue_in = '0;
         end
         SEQ_MEM: begin
            if (issuing) begin
               issue_in = issue_ff + 3'd1;
            end
            if (rd_pend_ff) begin
               if (dec_ff.mem_to_read) begin
                  rdval_in = mem_rdata;
               end else begin
                  tx_in = tx_ff | (64'(mem_rdata) << {rd_lane_ff, 3'b000});
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_ch.payload.tx_valid     = dec_ff.tx_valid;
      rsp_ch.payload.tx_bytes     = tx_ff;
      rsp_ch.payload.finished     = dec_ff.finished;
      rsp_ch.payload.succeeded    = dec_ff.finished && (st_ff.offset != 11'd0) &&
                                    (st_ff.offset == st_ff.total);
      rsp_ch.payload.abort_reason = dec_ff.abort_reason;
      rsp_ch.payload.read_value   = rdval_ff;
      rsp_ch.payload.final_length = st_ff.total;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff     <= SEQ_IDLE;
         rd_pend_ff <= 1'b0;
         st_ff      <= '{offset: '0, total: '0, last_cmd: CMD_ABORT, toggle: 1'b0,
                         index: '0, subindex: '0, active: 1'b0};
      end else begin
         seq_ff     <= seq_in;
         rd_pend_ff <= rd_pend_in;
         st_ff      <= st_in;
      end
      req_ff     <= req_in;
      dec_ff     <= dec_in;
      issue_ff   <= issue_in;
      rd_lane_ff <= rd_lane_in;
      tx_ff      <= tx_in;
      rdval_ff   <= rdval_in;
   end

   // A new word is never taken while a result word is still on offer.
   assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> !rsp_ch.valid)
      else $error("input taken while a result is pending");

   // After a word is accepted the engine stays busy for the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ch.ready && !rsp_ch.valid)
      else $error("engine not busy after accept");

   // Success is only reported on the word that ends a transfer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.payload.succeeded |-> rsp_ch.payload.finished)
      else $error("success without finish");

   // No frame bytes are shown unless a frame is sent.
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.payload.tx_valid |-> rsp_ch.payload.tx_bytes == 64'd0)
      else $error("frame bytes without a frame");

endmodule

[sim/sdo_transfer_checker.sv]
`timescale 1ns / 1ps

// Watches both channels of the SDO transfer engine, predicts the result word
// for every accepted request word and compares it with what comes out.
module sdo_transfer_checker import sdo_pkg::*; (
   input logic   clock,
   input logic   reset,
   sdo_req_if    req_mon,
   sdo_rsp_if    rsp_mon,
   output int    fail_count,
   output int    pending
);

   localparam int BUF_BYTES = BUFFER_BYTES_DEFAULT;

   logic [7:0]  image_store [BUF_BYTES];
   int          cur_offset;
   int          cur_total;
   logic [2:0]  sent_cmd;
   logic        sent_toggle;
   logic [15:0] obj_index;
   logic [7:0]  obj_subindex;
   logic        busy;

   logic        out_flag;
   logic [63:0] out_frame;

   rsp_word_type expected_words[$];

   function automatic logic [63:0] frame_head(input logic [7:0] byte0);
      return {32'b0, obj_subindex, obj_index, byte0};
   endfunction

   function automatic void send_frame(input logic [63:0] frame, input logic [2:0] cmd,
                                      input logic toggle);
      out_flag = 1'b1;
      out_frame = frame;
      sent_cmd = cmd;
      sent_toggle = toggle;
   endfunction

   function automatic int clamp_len(input longint v);
      return (v > BUF_BYTES) ? BUF_BYTES : int'(v);
   endfunction

   // Next download segment: up to seven bytes from the buffer.
   function automatic void send_download_segment(input logic toggle);
      int          remaining;
      int          count;
      logic [63:0] frame;
      remaining = (cur_total > cur_offset) ? cur_total - cur_offset : 0;
      count = (remaining > 7) ? 7 : remaining;
      frame = '0;
      frame[7:0] = {3'b000, toggle, 3'(7 - count), (count == remaining)};
      for (int i = 0; i < count; i++)
         if (cur_offset + i < BUF_BYTES) frame[8*(i+1) +: 8] = image_store[cur_offset + i];
      cur_offset += count;
      send_frame(frame, CMD_DL_SEG, toggle);
   endfunction

   function automatic void send_upload_request(input logic toggle);
      send_frame({56'b0, 3'b011, toggle, 4'b0000}, CMD_UL_SEG, toggle);
   endfunction

   function automatic rsp_word_type step_engine(input req_word_type w);
      rsp_word_type r;
      logic [31:0]  code;
      logic [31:0]  shown;
      logic         fin;
      logic [63:0]  fr;
      logic [7:0]   b0;
      logic         same;
      logic         tog;
      logic         s_bit;
      logic         e_bit;
      logic [31:0]  ds;
      logic [63:0]  frame;
      int           n;
      int           lim;
      r = '0;
      code = '0;
      shown = '0;
      fin = 1'b0;
      out_flag = 1'b0;
      out_frame = '0;
      fr = w.frame_bytes;
      b0 = fr[7:0];
      same = (fr[23:8] == obj_index) && (fr[31:24] == obj_subindex);
      tog = b0[4];
      case (w.req_type)
         REQ_LOAD: image_store[w.byte_addr] = w.byte_value;
         REQ_READ: r.read_value = image_store[w.byte_addr];
         REQ_START_DL, REQ_START_UL: begin
            obj_index = w.object_index;
            obj_subindex = w.object_subindex;
            cur_total = clamp_len(w.transfer_len);
            cur_offset = 0;
            busy = 1'b1;
            if (w.req_type == REQ_START_UL) begin
               send_frame(frame_head(8'h40), CMD_INIT_UL, 1'b0);
            end else if (cur_total > 4) begin
               send_frame(frame_head(8'h21) | (64'(cur_total) << 32), CMD_INIT_DL, 1'b0);
            end else begin
               // Expedited download; a zero length wraps n to zero.
               frame = frame_head({4'b0010, 2'(4 - cur_total), 2'b11});
               for (int i = 0; i < cur_total; i++) frame[8*(i+4) +: 8] = image_store[i];
               cur_offset = cur_total;
               send_frame(frame, CMD_INIT_DL, 1'b0);
            end
         end
         REQ_TIMEOUT: if (busy) code = CODE_TIMEOUT;
         REQ_FRAME: if (busy) begin
            case (b0[7:5])
               CMD_UL_SEG: begin
                  if (sent_cmd != CMD_INIT_DL || !same) code = CODE_GENERAL;
                  else if (cur_offset < cur_total) send_download_segment(1'b0);
                  else fin = 1'b1;
               end
               CMD_INIT_DL: begin
                  if (sent_cmd != CMD_DL_SEG) code = CODE_GENERAL;
                  else if (tog != sent_toggle) code = CODE_TOGGLE;
                  else if (cur_offset < cur_total) send_download_segment(!tog);
                  else fin = 1'b1;
               end
               CMD_INIT_UL: begin
                  s_bit = b0[0];
                  e_bit = b0[1];
                  ds = '0;
                  if (e_bit && s_bit) ds = 32'(4 - b0[3:2]);
                  else if (s_bit) ds = fr[63:32];
                  if (sent_cmd != CMD_INIT_UL || !same) begin
                     code = CODE_GENERAL;
                  end else if (!(ds == 0 || cur_total == 0 || ds == cur_total)) begin
                     code = CODE_LENGTH;
                  end else if (e_bit && !(ds <= 4 && cur_total <= 4)) begin
                     code = CODE_GENERAL;
                  end else if (e_bit) begin
                     if (cur_total == 0) cur_total = s_bit ? int'(ds) : 4;
                     for (int i = 0; i < cur_total && i < 4; i++)
                        image_store[i] = fr[8*(4+i) +: 8];
                     cur_offset = cur_total;
                     fin = 1'b1;
                  end else begin
                     if (s_bit && cur_total == 0) cur_total = clamp_len(ds);
                     send_upload_request(1'b0);
                  end
               end
               CMD_DL_SEG: begin
                  n = 7 - b0[3:1];
                  lim = (cur_total != 0) ? cur_total : BUF_BYTES;
                  if (sent_cmd != CMD_UL_SEG) begin
                     code = CODE_GENERAL;
                  end else if (tog != sent_toggle) begin
                     code = CODE_TOGGLE;
                  end else if (cur_offset + n > lim) begin
                     code = CODE_LENGTH;
                  end else begin
                     for (int i = 0; i < n; i++)
                        if (cur_offset + i < BUF_BYTES)
                           image_store[cur_offset + i] = fr[8*(1+i) +: 8];
                     cur_offset += n;
                     if (b0[0] || cur_offset == cur_total) begin
                        if (cur_total == 0) cur_total = cur_offset;
                        fin = 1'b1;
                     end else begin
                        send_upload_request(!tog);
                     end
                  end
               end
               CMD_ABORT: begin
                  shown = fr[63:32];
                  cur_offset = 0;
                  fin = 1'b1;
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      if (code != 0) begin
         send_frame(frame_head(8'h80) | (64'(code) << 32), CMD_ABORT, 1'b0);
         shown = code;
         cur_offset = 0;
         fin = 1'b1;
      end
      if (fin) busy = 1'b0;
      r.tx_valid = out_flag;
      r.tx_bytes = out_flag ? out_frame : '0;
      r.finished = fin;
      r.succeeded = fin && cur_offset != 0 && cur_offset == cur_total;
      r.abort_reason = shown;
      r.final_length = 11'(cur_total);
      return r;
   endfunction

   int mismatch_count;

   function automatic void check_field(input string field, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         mismatch_count++;
         fail_count++;
         if (mismatch_count <= 10)
            $display("mismatch in %s: expected %h, got %h", field, want, got);
      end
   endfunction

   initial begin
      fail_count = 0;
      mismatch_count = 0;
      cur_offset = 0;
      cur_total = 0;
      sent_cmd = CMD_ABORT;
      sent_toggle = 1'b0;
      obj_index = '0;
      obj_subindex = '0;
      busy = 1'b0;
      for (int i = 0; i < BUF_BYTES; i++) image_store[i] = '0;
   end

   assign pending = expected_words.size();

   always @(posedge clock) begin
      rsp_word_type want;
      rsp_word_type got;
      if (!reset) begin
         if (req_mon.valid && req_mon.ready)
            expected_words.push_back(step_engine(req_mon.payload));
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = rsp_mon.payload;
            if (expected_words.size() == 0) begin
               fail_count++;
               $display("result word with nothing expected: %h", got);
            end else begin
               want = expected_words.pop_front();
               check_field("tx_valid", 64'(want.tx_valid), 64'(got.tx_valid));
               check_field("tx_bytes", want.tx_bytes, got.tx_bytes);
               check_field("finished", 64'(want.finished), 64'(got.finished));
               check_field("succeeded", 64'(want.succeeded), 64'(got.succeeded));
               check_field("abort_reason", 64'(want.abort_reason), 64'(got.abort_reason));
               check_field("read_value", 64'(want.read_value), 64'(got.read_value));
               check_field("final_length", 64'(want.final_length), 64'(got.final_length));
            end
         end
      end
   end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

// Stimulus and verdict for the SDO client transfer engine. The checker beside
// the block does all prediction and comparison; this module only produces
// request words, paces the result channel and decides pass or fail.
module tb_top;
   import sdo_pkg::*;

   localparam int ITEM_TARGET = 1950;
   localparam int STALL_LIMIT = 6000;
   localparam int HOLD_CYCLES = 400;

   logic clock;
   logic reset;

   sdo_req_if req_ch ();
   sdo_rsp_if rsp_ch ();

   int fail_count;
   int pending;
   int sent_words;
   int src_idle;
   int snk_idle;
   bit hold_request;
   int quiet_cycles;

   sdo_client_transfer_engine_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   sdo_transfer_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // The receiver either follows the current idle rate or, when asked, holds
   // off for a long stretch so that the engine backs up and stalls its input.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ch.ready <= !reset && ($urandom_range(99) >= snk_idle);
      end
   end

   // Watchdog: a run in which no word moves on either channel for a long time
   // has hung.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == STALL_LIMIT) begin
            $display("sdo_client_transfer_engine_core regression: fail");
            $finish;
         end
      end
   end

   // A request word with every field random, so that the fields the request
   // type does not use still see both values on every bit.
   function automatic req_word_type random_word(input logic [2:0] kind);
      req_word_type w;
      w.req_type = kind;
      w.object_index = 16'($urandom);
      w.object_subindex = 8'($urandom);
      w.transfer_len = 11'($urandom);
      w.byte_addr = 10'($urandom);
      w.byte_value = 8'($urandom);
      w.frame_bytes = {32'($urandom), 32'($urandom)};
      return w;
   endfunction

   // Offers one word, with random idle cycles ahead of it, and returns at the
   // clock edge where it is taken. The valid is kept high between words that
   // follow each other without a gap.
   task automatic offer(input req_word_type w);
      while ($urandom_range(99) < src_idle) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= w;
      do @(posedge clock); while (!req_ch.ready);
      sent_words++;
   endtask

   task automatic offer_frame(input logic [7:0] byte0, input logic [15:0] ix,
                              input logic [7:0] sb, input logic [31:0] data);
      req_word_type w;
      w = random_word(REQ_FRAME);
      w.frame_bytes = {data, sb, ix, byte0};
      offer(w);
   endtask

   task automatic offer_start(input logic [2:0] kind, input logic [15:0] ix,
                              input logic [7:0] sb, input int len);
      req_word_type w;
      w = random_word(kind);
      w.object_index = ix;
      w.object_subindex = sb;
      w.transfer_len = 11'(len);
      offer(w);
   endtask

   task automatic offer_byte(input logic [2:0] kind, input logic [9:0] addr,
                             input logic [7:0] value);
      req_word_type w;
      w = random_word(kind);
      w.byte_addr = addr;
      w.byte_value = value;
      offer(w);
   endtask

   // Now and then a transfer is cut short by a timeout or by a stray frame.
   task automatic maybe_interrupt(input bit clean, output bit hit);
      hit = !clean && ($urandom_range(99) < 3);
      if (hit) begin
         if ($urandom_range(1)) offer(random_word(REQ_TIMEOUT));
         else offer(random_word(REQ_FRAME));
      end
   endtask

   // A download as a well-behaved server would answer it. Segment responses
   // alternate their toggle bit; a flipped toggle ends the sequence.
   task automatic run_download(input int len);
      logic [15:0] ix;
      logic [7:0]  sb;
      logic [7:0]  byte0;
      int          total;
      int          done_bytes;
      bit          tog;
      bit          hit;
      ix = 16'($urandom);
      sb = 8'($urandom);
      total = (len > 1024) ? 1024 : len;
      offer_start(REQ_START_DL, ix, sb, len);
      maybe_interrupt(1'b0, hit);
      if (hit) return;
      offer_frame(8'h60, ix, sb, $urandom);
      if (total <= 4) return;
      done_bytes = (total < 7) ? total : 7;
      tog = 1'b0;
      forever begin
         maybe_interrupt(1'b0, hit);
         if (hit) return;
         byte0 = {3'b001, tog, 4'b0000};
         if ($urandom_range(99) < 3) begin
            offer_frame(byte0 ^ 8'h10, ix, sb, $urandom);
            return;
         end
         offer_frame(byte0, ix, sb, $urandom);
         if (done_bytes >= total) return;
         done_bytes += (total - done_bytes > 7) ? 7 : total - done_bytes;
         tog = !tog;
      end
   endtask

   // An upload: expedited where the length allows it, otherwise segmented with
   // or without an indicated size. Segment data is random.
   task automatic run_upload(input int len, input bit clean);
      logic [15:0] ix;
      logic [7:0]  sb;
      logic [7:0]  byte0;
      int          total;
      int          seg_total;
      int          got_bytes;
      int          n;
      int          size;
      bit          sized;
      bit          tog;
      bit          hit;
      ix = 16'($urandom);
      sb = 8'($urandom);
      total = (len > 1024) ? 1024 : len;
      offer_start(REQ_START_UL, ix, sb, len);
      maybe_interrupt(clean, hit);
      if (hit) return;
      if (!clean && total <= 4 && $urandom_range(1)) begin
         if (total == 0 && $urandom_range(1)) begin
            offer_frame(8'h42, ix, sb, $urandom);
         end else begin
            size = (total != 0) ? total : $urandom_range(1, 4);
            offer_frame({4'b0100, 2'(4 - size), 2'b11}, ix, sb, $urandom);
         end
         return;
      end
      sized = clean || $urandom_range(3) != 0;
      seg_total = (total != 0) ? total : $urandom_range(1, 60);
      offer_frame(sized ? 8'h41 : 8'h40, ix, sb, sized ? 32'(seg_total) : $urandom);
      got_bytes = 0;
      tog = 1'b0;
      while (got_bytes < seg_total) begin
         maybe_interrupt(clean, hit);
         if (hit) return;
         n = (seg_total - got_bytes > 7) ? 7 : seg_total - got_bytes;
         byte0 = {3'b000, tog, 3'(7 - n), (got_bytes + n == seg_total)};
         if (!clean && $urandom_range(99) < 3) begin
            offer_frame(byte0 ^ 8'h10, ix, sb, $urandom);
            return;
         end
         offer_frame(byte0, ix, sb, $urandom);
         got_bytes += n;
         tog = !tog;
      end
   endtask

   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      while (pending != 0) @(posedge clock);
   endtask

   function automatic int random_length();
      if ($urandom_range(99) == 0) return 1024;
      return $urandom_range(0, 40);
   endfunction

   initial begin
      int pick;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      reset = 1'b1;
      hold_request = 1'b0;
      sent_words = 0;
      src_idle = 26;
      snk_idle = 71;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Fill the whole buffer through one clean segmented upload, so that no
      // later read or download segment ever touches a byte never written.
      run_upload(1024, 1'b1);

      // Directed part: buffer edges, idle frames and timeouts, unused request
      // types, the zero-length download, a start while active with an
      // oversized length, an unknown command, a server abort, a length
      // mismatch, an expedited upload without a size, a wrong object, a
      // toggle error and a segment overflow.
      offer_byte(REQ_LOAD, 10'd0, 8'h00);
      offer_byte(REQ_LOAD, 10'd1023, 8'hff);
      offer_byte(REQ_READ, 10'd0, 8'h00);
      offer_byte(REQ_READ, 10'd1023, 8'h00);
      offer(random_word(REQ_TIMEOUT));
      offer(random_word(REQ_FRAME));
      offer(random_word(3'd6));
      offer(random_word(3'd7));
      offer_start(REQ_START_DL, 16'hffff, 8'hff, 0);
      offer_frame(8'h60, 16'hffff, 8'hff, 32'h0);
      offer_start(REQ_START_DL, 16'h1234, 8'h01, 4);
      offer_start(REQ_START_UL, 16'h0000, 8'h00, 2047);
      offer_frame(8'ha0, 16'h0000, 8'h00, 32'hdead_beef);
      offer_frame(8'h80, 16'h0000, 8'h00, 32'h0800_0020);
      offer_start(REQ_START_UL, 16'h2000, 8'h05, 3);
      offer_frame(8'h4b, 16'h2000, 8'h05, 32'hffff_ffff);
      offer_start(REQ_START_UL, 16'h2001, 8'h00, 0);
      offer_frame(8'h42, 16'h2001, 8'h00, 32'h8765_4321);
      offer_start(REQ_START_DL, 16'h3000, 8'h10, 10);
      offer_frame(8'h60, 16'h3001, 8'h10, 32'h0);
      offer_start(REQ_START_DL, 16'h3000, 8'h10, 10);
      offer_frame(8'h60, 16'h3000, 8'h10, 32'h0);
      offer_frame(8'h30, 16'h3000, 8'h10, 32'h0);
      offer_start(REQ_START_UL, 16'h4000, 8'h20, 5);
      offer_frame(8'h41, 16'h4000, 8'h20, 32'd5);
      offer_frame(8'h00, 16'h4000, 8'h20, 32'h0);

      // Random part in three idle settings. Each change of setting first lets
      // the engine drain; the last one also starts a long receiver hold while
      // words keep coming.
      while (sent_words < ITEM_TARGET) begin
         if (sent_words >= 650 && src_idle == 26) begin
            wait_for_results();
            src_idle = 71;
            snk_idle = 26;
         end else if (sent_words >= 1300 && src_idle == 71) begin
            wait_for_results();
            src_idle = 0;
            snk_idle = 0;
            hold_request = 1'b1;
         end
         pick = $urandom_range(99);
         if (pick < 10) offer(random_word(REQ_LOAD));
         else if (pick < 15) offer(random_word(REQ_READ));
         else if (pick < 23) offer(random_word(3'($urandom)));
         else if (pick < 65) run_download(random_length());
         else run_upload(random_length(), 1'b0);
      end

      wait_for_results();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("sdo_client_transfer_engine_core regression: pass");
      end else begin
         $display("sdo_client_transfer_engine_core regression: fail");
      end
      $finish;
   end

endmodule
